// File: src/rrps_pkg.sv
// rrps_pkg: constants shared by the rounded rectangle pixel shader
// register map, register bus widths and coverage codes; no dependencies

package rrps_pkg;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
   localparam logic [2:0] REG_RECT_TOP      = 3'd1;
   localparam logic [2:0] REG_RECT_WIDTH    = 3'd2;
   localparam logic [2:0] REG_RECT_HEIGHT   = 3'd3;
   localparam logic [2:0] REG_CORNER_RADIUS = 3'd4;
   localparam logic [2:0] REG_BODY_COLOUR   = 3'd5;
   localparam logic [2:0] REG_EDGE_COLOUR   = 3'd6;

   localparam int COLOUR_WIDTH = 16;

   localparam logic [1:0] COV_NONE = 2'd0;
   localparam logic [1:0] COV_BODY = 2'd1;
   localparam logic [1:0] COV_EDGE = 2'd2;

endpackage

// File: src/rounded_rect_pixel_shader.sv
// rounded_rect_pixel_shader: shades one pixel a beat against a rounded rectangle
// an accepted req beat passes stages 1 to 4, the root stages and the output stage to its rsp beat
// throughput one pixel per cycle while rsp is not stalled; empty stages close up while rsp is stalled
// the corner root takes one stage per root bit, COORD_WIDTH - 1 stages
// synchronous reset clears all valid bits and the configuration registers to zero
// depends on rrps_pkg

module rounded_rect_pixel_shader #(
   parameter int COORD_WIDTH = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rrps_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rrps_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rrps_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [COORD_WIDTH-1:0]              req_pixel_col,
   input  logic [COORD_WIDTH-1:0]              req_pixel_row,
   input  logic [rrps_pkg::COLOUR_WIDTH-1:0]   req_under_colour,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rrps_pkg::COLOUR_WIDTH-1:0]   rsp_new_colour,
   output logic [1:0]                          rsp_covered
);
   import rrps_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int RW = COORD_WIDTH - 1;
   localparam int OW = COORD_WIDTH + 2;

   typedef struct packed {
      logic [OW-1:0]           col_off;
      logic [RW-1:0]           rad;
      logic [COLOUR_WIDTH-1:0] under;
      logic                    in_rect;
      logic                    edge_hit;
   } pass_type;

   // configuration registers
   logic signed [CW:0]      left_ff;
   logic signed [CW:0]      top_ff;
   logic [CW-1:0]           width_ff;
   logic [CW-1:0]           height_ff;
   logic signed [CW-1:0]    radius_ff;
   logic [COLOUR_WIDTH-1:0] body_ff;
   logic [COLOUR_WIDTH-1:0] edge_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= '0;
         body_ff   <= '0;
         edge_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_RECT_LEFT:     left_ff   <= csr_pwdata[CW:0];
            REG_RECT_TOP:      top_ff    <= csr_pwdata[CW:0];
            REG_RECT_WIDTH:    width_ff  <= csr_pwdata[CW-1:0];
            REG_RECT_HEIGHT:   height_ff <= csr_pwdata[CW-1:0];
            REG_CORNER_RADIUS: radius_ff <= csr_pwdata[CW-1:0];
            REG_BODY_COLOUR:   body_ff   <= csr_pwdata[COLOUR_WIDTH-1:0];
            REG_EDGE_COLOUR:   edge_ff   <= csr_pwdata[COLOUR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_RECT_LEFT:     csr_prdata[CW:0]             = left_ff;
         REG_RECT_TOP:      csr_prdata[CW:0]             = top_ff;
         REG_RECT_WIDTH:    csr_prdata[CW-1:0]           = width_ff;
         REG_RECT_HEIGHT:   csr_prdata[CW-1:0]           = height_ff;
         REG_CORNER_RADIUS: csr_prdata[CW-1:0]           = radius_ff;
         REG_BODY_COLOUR:   csr_prdata[COLOUR_WIDTH-1:0] = body_ff;
         REG_EDGE_COLOUR:   csr_prdata[COLOUR_WIDTH-1:0] = edge_ff;
         default:           csr_prdata                   = '0;
      endcase
   end

   // legal radius: negative or above half the height becomes half the height
   logic [RW-1:0] half_h;
   logic [RW-1:0] rad_legal;

   assign half_h    = height_ff[CW-1:1];
   assign rad_legal = (radius_ff[CW-1] || (radius_ff[CW-2:0] > half_h))
                      ? half_h : radius_ff[RW-1:0];

   // stage enables, each stage loads when empty or when its successor loads
   logic          en1, en2, en3, en4, en_out;
   logic [RW-1:0] rt_en;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [RW-1:0] rt_valid_ff;
   logic          rsp_valid_ff;

   assign en_out = !rsp_valid_ff || !rsp_stall;

   genvar g;
   generate
      for (g = 0; g < RW; g++) begin : g_en
         if (g == RW - 1) begin : g_last
            assign rt_en[g] = !rt_valid_ff[g] || en_out;
         end else begin : g_mid
            assign rt_en[g] = !rt_valid_ff[g] || rt_en[g+1];
         end
      end
   endgenerate

   assign en4 = !s4_valid_ff || rt_en[0];
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_stall = !en1;

   // stage 1: offsets from the rectangle's top left corner
   logic [OW-1:0]           s1_col_off_ff, s1_row_off_ff;
   logic [OW-1:0]           s1_col_off_in, s1_row_off_in;
   logic [COLOUR_WIDTH-1:0] s1_under_ff;

   assign s1_col_off_in = {2'b00, req_pixel_col} - {left_ff[CW], left_ff};
   assign s1_row_off_in = {2'b00, req_pixel_row} - {top_ff[CW], top_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_col_off_ff <= s1_col_off_in;
         s1_row_off_ff <= s1_row_off_in;
         s1_under_ff   <= req_under_colour;
      end
   end

   // stage 2: rectangle test, border test and row distance from the arc center
   logic signed [OW-1:0] col_s, row_s, w_s, h_s;
   logic                 in_rect, border;
   logic [CW-1:0]        row_u, h_minus_r, dy_top, dy_bot;
   pass_type             s2_pass_in, s2_pass_ff;
   logic [RW-1:0]        s2_dy_in, s2_dy_ff;

   always_comb begin
      col_s     = $signed(s1_col_off_ff);
      row_s     = $signed(s1_row_off_ff);
      w_s       = $signed({2'b00, width_ff});
      h_s       = $signed({2'b00, height_ff});
      in_rect   = (col_s >= 0) && (col_s < w_s) && (row_s >= 0) && (row_s < h_s);
      border    = (col_s == 0) || (col_s == w_s - 1) || (row_s == 0) || (row_s == h_s - 1);
      row_u     = s1_row_off_ff[CW-1:0];
      h_minus_r = height_ff - {1'b0, rad_legal};
      dy_top    = {1'b0, rad_legal} - row_u;
      dy_bot    = row_u - h_minus_r;
      if (row_u < {1'b0, rad_legal}) begin
         s2_dy_in = dy_top[RW-1:0];
      end else if (row_u >= h_minus_r) begin
         s2_dy_in = dy_bot[RW-1:0];
      end else begin
         s2_dy_in = '0;
      end
      s2_pass_in.col_off  = s1_col_off_ff;
      s2_pass_in.rad      = rad_legal;
      s2_pass_in.under    = s1_under_ff;
      s2_pass_in.in_rect  = in_rect;
      s2_pass_in.edge_hit = in_rect && border && (edge_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_pass_ff <= s2_pass_in;
         s2_dy_ff   <= s2_dy_in;
      end
   end

   // stage 3: squares of radius and row distance
   pass_type        s3_pass_ff;
   logic [2*RW-1:0] s3_rr_ff, s3_dd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_pass_ff <= s2_pass_ff;
         s3_rr_ff   <= s2_pass_ff.rad * s2_pass_ff.rad;
         s3_dd_ff   <= s2_dy_ff * s2_dy_ff;
      end
   end

   // stage 4: radicand
   pass_type        s4_pass_ff;
   logic [2*RW-1:0] s4_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_pass_ff <= s3_pass_ff;
         s4_sq_ff   <= s3_rr_ff - s3_dd_ff;
      end
   end

   // floor square root, one result bit per stage
   pass_type        rt_pass_ff [RW];
   logic [RW+1:0]   rt_rem_ff  [RW];
   logic [RW-1:0]   rt_root_ff [RW];
   logic [2*RW-1:0] rt_sq_ff   [RW];

   generate
      for (g = 0; g < RW; g++) begin : g_root
         pass_type        pass_prev;
         logic            valid_prev;
         logic [RW+1:0]   rem_prev, rem_sh, trial, rem_in;
         logic [RW-1:0]   root_prev, root_in;
         logic [2*RW-1:0] sq_prev;
         logic            ge;

         if (g == 0) begin : g_first
            assign pass_prev  = s4_pass_ff;
            assign valid_prev = s4_valid_ff;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign sq_prev    = s4_sq_ff;
         end else begin : g_next
            assign pass_prev  = rt_pass_ff[g-1];
            assign valid_prev = rt_valid_ff[g-1];
            assign rem_prev   = rt_rem_ff[g-1];
            assign root_prev  = rt_root_ff[g-1];
            assign sq_prev    = rt_sq_ff[g-1];
         end

         assign rem_sh  = {rem_prev[RW-1:0], sq_prev[2*RW-1 -: 2]};
         assign trial   = {root_prev, 2'b01};
         assign ge      = rem_sh >= trial;
         assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
         assign root_in = {root_prev[RW-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               rt_valid_ff[g] <= 1'b0;
            end else if (rt_en[g]) begin
               rt_valid_ff[g] <= valid_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (rt_en[g]) begin
               rt_pass_ff[g] <= pass_prev;
               rt_rem_ff[g]  <= rem_in;
               rt_root_ff[g] <= root_in;
               rt_sq_ff[g]   <= {sq_prev[2*RW-3:0], 2'b00};
            end
         end
      end
   endgenerate

   // output stage: row inset and colour choice
   pass_type                fin_pass;
   logic [RW-1:0]           inset;
   logic signed [OW-1:0]    fin_col, fin_lo, fin_hi;
   logic                    in_body;
   logic [COLOUR_WIDTH-1:0] rsp_new_colour_ff, rsp_new_colour_in;
   logic [1:0]              rsp_covered_ff, rsp_covered_in;

   always_comb begin
      fin_pass = rt_pass_ff[RW-1];
      inset    = fin_pass.rad - rt_root_ff[RW-1];
      fin_col  = $signed(fin_pass.col_off);
      fin_lo   = $signed({3'b000, inset});
      fin_hi   = $signed({2'b00, width_ff}) - fin_lo;
      in_body  = fin_pass.in_rect && (fin_col >= fin_lo) && (fin_col < fin_hi);
      if (fin_pass.edge_hit) begin
         rsp_new_colour_in = edge_ff;
         rsp_covered_in    = COV_EDGE;
      end else if (in_body) begin
         rsp_new_colour_in = body_ff;
         rsp_covered_in    = COV_BODY;
      end else begin
         rsp_new_colour_in = fin_pass.under;
         rsp_covered_in    = COV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= rt_valid_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_new_colour_ff <= rsp_new_colour_in;
         rsp_covered_ff    <= rsp_covered_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_colour = rsp_new_colour_ff;
   assign rsp_covered    = rsp_covered_ff;

endmodule
